### hdl/obm_pkg.sv
// Package for the order book matcher: codes, widths and shared types.
// Used by obm_ctrl, obm_datapath and order_book_matcher_top.
package obm_pkg;
	localparam int BookDepthDefault  = 64;
	localparam int StockCountDefault = 5;

	localparam logic [1:0] OP_BUY    = 2'd0;
	localparam logic [1:0] OP_SELL   = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_DROPPED  = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	// controller -> datapath commands
	typedef struct packed {
		logic load;       // capture input word
		logic scan_start; // clear scan best / index
		logic scan_step;  // read one entry
		logic trade;      // apply fill to best entry
		logic rest;       // write residual into free slot
		logic cancel;     // invalidate cancel hit
		logic finish;     // load output register
	} obm_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic scan_last;  // current step is the last entry
		logic found;      // a best/hit entry exists
		logic free_found; // a free slot exists
		logic qty_zero;   // working quantity is zero
		logic bad_stock;  // instrument out of range
		logic [1:0] op;
	} obm_stat_t;
endpackage

### hdl/obm_datapath.sv
// Datapath of the order book matcher: book memories, one-entry-per-cycle scan,
// trade, rest and cancel updates, result register. Depends on obm_pkg.
module obm_datapath #(
	parameter int BOOK_DEPTH  = obm_pkg::BookDepthDefault,
	parameter int STOCK_COUNT = obm_pkg::StockCountDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  obm_pkg::obm_cmd_t cmd,
	output obm_pkg::obm_stat_t stat,
	input  logic [1:0]        operation,
	input  logic [19:0]       order_id,
	input  logic [2:0]        stock_id,
	input  logic [15:0]       quantity,
	input  logic [19:0]       price,
	output logic [15:0]       remaining_quantity,
	output logic [1:0]        status
);
	import obm_pkg::*;

	localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

	// book storage: valid bits in flops, the rest in memory arrays
	logic [BOOK_DEPTH-1:0] valid_q;
	logic                  side_mem [BOOK_DEPTH];
	logic [3:0]            stock_mem[BOOK_DEPTH];
	logic [19:0]           id_mem   [BOOK_DEPTH];
	logic [15:0]           qty_mem  [BOOK_DEPTH];
	logic [19:0]           price_mem[BOOK_DEPTH];
	logic [31:0]           arr_mem  [BOOK_DEPTH];
	logic [31:0]           arrival_q;

	// captured word
	logic [1:0]  op_q;
	logic [19:0] id_q;
	logic [3:0]  stk_q;
	logic [15:0] qty_q;
	logic [19:0] price_q;

	// scan state
	logic [IW-1:0] idx_q;
	logic          best_ok_q;
	logic [IW-1:0] best_q;
	logic [19:0]   best_price_q;
	logic [31:0]   best_age_q;
	logic [15:0]   best_qty_q;
	logic          free_ok_q;
	logic [IW-1:0] free_q;

	// registered entry read, evaluated in the cycle after the read
	logic          rd_ok_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          rd_valid_s1;
	logic          rd_side_s1;
	logic [3:0]    rd_stock_s1;
	logic [19:0]   rd_id_s1;
	logic [15:0]   rd_qty_s1;
	logic [19:0]   rd_price_s1;
	logic [31:0]   rd_arr_s1;

	// current entry
	logic        e_valid, e_side, cand, better;
	logic [3:0]  e_stock;
	logic [19:0] e_id, e_price;
	logic [15:0] e_qty;
	logic [31:0] e_age;
	logic [15:0] fill;

	always_comb begin
		e_valid = rd_valid_s1;
		e_side  = rd_side_s1;
		e_stock = rd_stock_s1;
		e_id    = rd_id_s1;
		e_price = rd_price_s1;
		e_qty   = rd_qty_s1;
		e_age   = arrival_q - rd_arr_s1;
		better  = 1'b0;
		if (op_q == OP_CANCEL) begin
			cand = e_valid && (e_id == id_q);
			if (cand) better = !best_ok_q || (e_age > best_age_q);
		end else begin
			cand = e_valid && (e_side != op_q[0]) && (e_stock == stk_q) &&
				((op_q == OP_BUY) ? (e_price <= price_q) : (e_price >= price_q));
			if (cand) begin
				better = !best_ok_q ||
					((op_q == OP_BUY) ? (e_price < best_price_q) : (e_price > best_price_q)) ||
					((e_price == best_price_q) && (e_age > best_age_q));
			end
		end
		fill = (best_qty_q < qty_q) ? best_qty_q : qty_q;
	end

	assign stat.scan_last  = (32'(idx_q) == 32'(BOOK_DEPTH - 1));
	assign stat.found      = best_ok_q;
	assign stat.free_found = free_ok_q;
	assign stat.qty_zero   = (qty_q == 16'd0);
	assign stat.bad_stock  = (stk_q == 4'd0) || (32'(stk_q) > 32'(STOCK_COUNT));
	assign stat.op         = op_q;

	// control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			arrival_q   <= '0;
			best_ok_q   <= 1'b0;
			free_ok_q   <= 1'b0;
			idx_q       <= '0;
			rd_ok_s1    <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_ok_s1    <= cmd.scan_step;
			rd_valid_s1 <= valid_q[idx_q];
			if (cmd.scan_start) begin
				idx_q     <= '0;
				best_ok_q <= 1'b0;
				free_ok_q <= 1'b0;
			end else begin
				if (cmd.scan_step && !stat.scan_last) idx_q <= idx_q + 1'b1;
				if (rd_ok_s1) begin
					if (better) best_ok_q <= 1'b1;
					if (!e_valid && !free_ok_q) free_ok_q <= 1'b1;
				end
			end
			if (cmd.trade && (fill == best_qty_q)) valid_q[best_q] <= 1'b0;
			if (cmd.cancel) valid_q[best_q] <= 1'b0;
			if (cmd.rest) begin
				valid_q[free_q] <= 1'b1;
				arrival_q       <= arrival_q + 32'd1;
			end
		end
	end

	// payload registers, memory reads and writes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			id_q    <= order_id;
			stk_q   <= {1'b0, stock_id};
			qty_q   <= quantity;
			price_q <= price;
		end
		if (cmd.scan_step) begin
			rd_idx_s1   <= idx_q;
			rd_side_s1  <= side_mem[idx_q];
			rd_stock_s1 <= stock_mem[idx_q];
			rd_id_s1    <= id_mem[idx_q];
			rd_qty_s1   <= qty_mem[idx_q];
			rd_price_s1 <= price_mem[idx_q];
			rd_arr_s1   <= arr_mem[idx_q];
		end
		if (rd_ok_s1) begin
			if (better) begin
				best_q       <= rd_idx_s1;
				best_price_q <= e_price;
				best_age_q   <= e_age;
				best_qty_q   <= e_qty;
			end
			if (!e_valid && !free_ok_q) free_q <= rd_idx_s1;
		end
		if (cmd.trade) begin
			qty_q            <= qty_q - fill;
			qty_mem[best_q]  <= best_qty_q - fill;
		end
		if (cmd.rest) begin
			side_mem[free_q]  <= op_q[0];
			stock_mem[free_q] <= stk_q;
			id_mem[free_q]    <= id_q;
			qty_mem[free_q]   <= qty_q;
			price_mem[free_q] <= price_q;
			arr_mem[free_q]   <= arrival_q;
		end
		if (cmd.finish) begin
			if (op_q == OP_CANCEL) begin
				remaining_quantity <= '0;
				status             <= best_ok_q ? ST_DONE : ST_NOTFOUND;
			end else if (op_q == OP_BUY || op_q == OP_SELL) begin
				remaining_quantity <= qty_q;
				status <= (stat.bad_stock || (qty_q != 16'd0 && !free_ok_q)) ?
					ST_DROPPED : ST_DONE;
			end else begin
				remaining_quantity <= '0;
				status             <= ST_DONE;
			end
		end
	end

	// a trade or cancel only ever touches a found entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.trade || cmd.cancel) |-> best_ok_q)
		else $error("trade/cancel without hit");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rest |-> (free_ok_q && !valid_q[free_q]))
		else $error("rest into occupied slot");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rest |=> (arrival_q == $past(arrival_q) + 32'd1))
		else $error("arrival stamp not advanced");
endmodule

### hdl/obm_ctrl.sv
// Controller of the order book matcher: sequences scan, trade, rest and
// cancel steps and runs the in/out handshake. Depends on obm_pkg.
module obm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output obm_pkg::obm_cmd_t  cmd,
	input  obm_pkg::obm_stat_t stat
);
	import obm_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DEC   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;
	localparam logic [2:0] S_LAST  = 3'd5;

	logic [2:0] state_q;
	logic       out_valid_q;
	logic       take;

	// one word in flight; accept when idle and the result slot is free or draining
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign take      = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = take;
		cmd.scan_start = (state_q == S_START);
		cmd.scan_step  = (state_q == S_SCAN);
		cmd.finish     = (state_q == S_FIN);
		if (state_q == S_DEC) begin
			if (stat.op == OP_CANCEL) cmd.cancel = stat.found;
			else if (stat.found && !stat.qty_zero) cmd.trade = 1'b1;
			else if (!stat.qty_zero && stat.free_found) cmd.rest = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (take) state_q <= S_START;
				S_START: begin
					if ((stat.op == OP_BUY || stat.op == OP_SELL) &&
						(stat.bad_stock || stat.qty_zero))
						state_q <= S_FIN;
					else if (stat.op == OP_CANCEL || stat.op == OP_BUY ||
						stat.op == OP_SELL)
						state_q <= S_SCAN;
					else
						state_q <= S_FIN;
				end
				S_SCAN: if (stat.scan_last) state_q <= S_LAST;
				// last entry read is evaluated here
				S_LAST: state_q <= S_DEC;
				S_DEC: begin
					if (stat.op != OP_CANCEL && stat.found && !stat.qty_zero)
						state_q <= S_START;
					else
						state_q <= S_FIN;
				end
				S_FIN: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == S_START))
		else $error("accepted word did not start");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> out_valid_q)
		else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.trade, cmd.rest, cmd.cancel}))
		else $error("conflicting book updates");
endmodule

### hdl/order_book_matcher_top.sv
// Order book matcher: one word at a time. A scan pass reads one book entry per
// cycle with a registered read. An order takes one scan pass per match, trading
// with the best entry after each, and a last pass that finds no match when it
// rests or drops; a fully filled order needs no such pass. A cancel takes one
// pass; a bad instrument, zero quantity or unused op skips the scan.
// Input stalls while a result is stalled. Reset (arst_n low, async) empties the book.
module order_book_matcher_top #(
	parameter int BOOK_DEPTH  = obm_pkg::BookDepthDefault,
	parameter int STOCK_COUNT = obm_pkg::StockCountDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [19:0] order_id,
	input  logic [2:0]  stock_id,
	input  logic [15:0] quantity,
	input  logic [19:0] price,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] remaining_quantity,
	output logic [1:0]  status
);
	import obm_pkg::*;

	obm_cmd_t  cmd;
	obm_stat_t stat;

	obm_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.cmd, .stat
	);

	obm_datapath #(.BOOK_DEPTH(BOOK_DEPTH), .STOCK_COUNT(STOCK_COUNT)) u_dp (
		.clk, .arst_n, .cmd, .stat, .operation, .order_id, .stock_id,
		.quantity, .price, .remaining_quantity, .status
	);
endmodule
